// ----- hw/rtl/csw_pkg.sv -----
// ----------------------------------------------------------------------------
// Capture stream watchdog package
// Shared types, register indexes and scaling constants of the watchdog.
// ----------------------------------------------------------------------------
package csw_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int BYTE_W   = 48;
    localparam int GOT_W    = 32;
    localparam int SINCE_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // 130% of the expected interval and 70% of the expected rate, scaled so
    // that both checks stay in integers.
    localparam logic [20:0] Q_SCALE = 21'd1300000;
    localparam logic [23:0] G_SCALE = 24'd10000000;

    localparam logic [7:0]  SLOW_CNT_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT_US  = 3'd4;

    localparam logic [7:0]  SLOW_LIMIT_RST = 8'd1;
    localparam logic [31:0] IDLE_LIMIT_RST = 32'd1000000;

    typedef enum logic [2:0] {
        V_OK    = 3'd0,
        V_DONE  = 3'd1,
        V_RETRY = 3'd2,
        V_WARN  = 3'd3,
        V_ABORT = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_target;
        logic [31:0]       expected_rate;
        logic [31:0]       transfer_bytes;
        logic [7:0]        slow_run_limit;
        logic [31:0]       idle_limit_us;
    } t_cfg;

    // Load strobes of the two judging stages.
    typedef struct packed {
        logic en2;
        logic en3;
    } t_stage_en;

    // One event after the slowness decision, as seen by the tracker.
    typedef struct packed {
        logic [GOT_W-1:0]  got;
        logic [BYTE_W-1:0] now;
        logic              hist;
        logic              slow;
    } t_judged;

endpackage

// ----- hw/rtl/csw_evt_if.sv -----
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one completed-transfer event.
// ----------------------------------------------------------------------------
interface csw_evt_if;
    logic               valid;
    logic               ready;
    logic [31:0]        rx_bytes;
    logic [47:0]        now_us;
    logic signed [31:0] gap_us;

    modport source (output valid, rx_bytes, now_us, gap_us, input ready);
    modport sink   (input valid, rx_bytes, now_us, gap_us, output ready);
endinterface

// ----- hw/rtl/csw_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one verdict and the running byte total.
// ----------------------------------------------------------------------------
interface csw_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [47:0] received_total;

    modport source (output valid, verdict, received_total, input ready);
    modport sink   (input valid, verdict, received_total, output ready);
endinterface

// ----- hw/rtl/csw_slow_judge.sv -----
// ----------------------------------------------------------------------------
// Slowness judge
// Two-stage datapath: registered products, then the registered slow flag.
// ----------------------------------------------------------------------------
module csw_slow_judge (
    input  logic                 i_clk,
    input  csw_pkg::t_stage_en   i_en,
    input  logic [30:0]          i_since,
    input  logic [31:0]          i_got,
    input  logic [31:0]          i_rate,
    input  logic [31:0]          i_transfer,
    output logic                 o_slow
);
    import csw_pkg::*;

    logic [62:0] r_p;
    logic [52:0] r_q;
    logic [55:0] r_g;
    logic [65:0] p7;
    logic        n_slow;
    logic        r_slow;

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_p <= i_since * i_rate;
            r_q <= i_transfer * Q_SCALE;
            r_g <= i_got * G_SCALE;
        end
    end

    // The rate check compares 7*p against got*10^7, which is the same as
    // p > floor(got*10^7 / 7).
    always_comb begin
        p7     = {r_p, 3'b000} - {3'b000, r_p};
        n_slow = ({1'b0, r_p} > {11'd0, r_q}) || (p7 > {10'd0, r_g});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_slow <= n_slow;
        end
    end

    assign o_slow = r_slow;

endmodule

// ----- hw/rtl/csw_tracker.sv -----
// ----------------------------------------------------------------------------
// Watchdog tracker
// Holds the byte total, times and slow-run state and forms each verdict.
// ----------------------------------------------------------------------------
module csw_tracker #(
    parameter int TIME_BITS = csw_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  csw_pkg::t_cfg        i_cfg,
    input  csw_pkg::t_judged     i_evt,
    output csw_pkg::t_verdict    o_verdict,
    output logic [47:0]          o_total
);
    import csw_pkg::*;

    logic [BYTE_W-1:0]    r_rc,   n_rc;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_last,  n_last;
    logic [7:0]           r_sc,   n_sc;
    logic                 r_retry, n_retry;
    logic                 r_warned, n_warned;

    logic [TIME_BITS+47:0] now_wide;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  ref_t;
    logic [TIME_BITS-1:0]  idle_t;
    logic [BYTE_W:0]       sum;
    logic [7:0]            sc_inc;
    logic [7:0]            lim;
    t_verdict              verdict;

    // Timestamps are kept to TIME_BITS bits and wrap there.
    assign now_wide = {{TIME_BITS{1'b0}}, i_evt.now};
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign idle_t   = TIME_BITS'(i_cfg.idle_limit_us);

    always_comb begin
        n_start  = (r_start == '0) ? now_t : r_start;
        n_rc     = r_rc;
        n_last   = r_last;
        n_sc     = r_sc;
        n_retry  = r_retry;
        n_warned = r_warned;
        sum      = {1'b0, r_rc} + {{(BYTE_W + 1 - GOT_W){1'b0}}, i_evt.got};
        if (i_evt.got != '0) begin
            n_rc   = sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];
            n_last = now_t;
        end
        ref_t   = (n_last != '0) ? n_last : n_start;
        sc_inc  = !i_evt.slow ? 8'd0 : ((r_sc == SLOW_CNT_MAX) ? r_sc : r_sc + 8'd1);
        lim     = (i_cfg.slow_run_limit == '0) ? 8'd1 : i_cfg.slow_run_limit;
        verdict = V_OK;

        priority if (i_cfg.byte_target != '0 && n_rc >= i_cfg.byte_target) begin
            verdict = V_DONE;
        end else if (!i_evt.hist || i_cfg.expected_rate == '0 ||
                     i_cfg.transfer_bytes == '0) begin
            verdict = V_OK;
        end else if (n_rc == '0) begin
            // Nothing has arrived yet: count slow events in a row.
            n_sc = sc_inc;
            if (sc_inc >= lim) begin
                if (!r_retry) begin
                    n_retry = 1'b1;
                    n_sc    = 8'd0;
                    verdict = V_RETRY;
                end else begin
                    verdict = V_ABORT;
                end
            end
        end else if (now_t >= ref_t && (now_t - ref_t) > idle_t) begin
            verdict = V_ABORT;
        end else if (i_evt.slow && !r_warned) begin
            n_warned = 1'b1;
            verdict  = V_WARN;
        end else begin
            verdict = V_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc     <= '0;
            r_start  <= '0;
            r_last   <= '0;
            r_sc     <= '0;
            r_retry  <= 1'b0;
            r_warned <= 1'b0;
        end else if (i_load) begin
            r_rc     <= n_rc;
            r_start  <= n_start;
            r_last   <= n_last;
            r_sc     <= n_sc;
            r_retry  <= n_retry;
            r_warned <= n_warned;
        end
    end

    assign o_verdict = verdict;
    assign o_total   = n_rc;

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_rc >= $past(r_rc))
        else $error("byte total went down");

    a_retry_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry |=> r_retry)
        else $error("retry flag cleared without reset");

    a_warn_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && verdict == V_WARN) |-> !r_warned)
        else $error("slowness warned twice");

    a_retry_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && verdict == V_RETRY) |=> r_sc == 8'd0)
        else $error("slow run not cleared after retry");

endmodule

// ----- hw/rtl/capture_stream_watchdog.sv -----
// ----------------------------------------------------------------------------
// Capture stream watchdog
// Judges each completed-transfer event and returns one verdict per event.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event per transfer: bytes delivered, a timestamp and the
//   interval since the previous event. o_res returns one verdict per event
//   (ok, done, retry run, warn slow, abort) with the saturated byte total.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while no
//   event is in flight.
//   A result passes through an input register, a product register, a
//   slow-flag register and the result register. Throughput is one event per
//   cycle while the receiver takes results; every stage has its own valid bit,
//   so the multiply stage sets the clock, not the rate.
//   When the receiver stalls, the result register holds and the stages
//   behind it keep filling; i_evt.ready drops only once the input register
//   is full and cannot move on.
//   Synchronous reset clears all stage valid bits, the byte total, the times
//   and the slow-run state, and returns the registers to their reset values.
// ----------------------------------------------------------------------------
module capture_stream_watchdog #(
    parameter int TIME_BITS = csw_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    csw_evt_if.sink                            i_evt,
    csw_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [csw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [csw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import csw_pkg::*;

    t_cfg r_cfg;

    logic r_v1, r_v2, r_v3, r_out_vld;
    logic en1, en_out;
    t_stage_en en;

    logic [31:0] r1_got;
    logic [47:0] r1_now;
    logic [31:0] r1_since;
    logic [31:0] r2_got, r3_got;
    logic [47:0] r2_now, r3_now;
    logic        r2_hist, r3_hist;
    logic        slow;

    t_judged   judged;
    t_verdict  trk_verdict;
    logic [47:0] trk_total;
    t_verdict  r_out_verdict;
    logic [47:0] r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_target    <= '0;
            r_cfg.expected_rate  <= '0;
            r_cfg.transfer_bytes <= '0;
            r_cfg.slow_run_limit <= SLOW_LIMIT_RST;
            r_cfg.idle_limit_us  <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTE_TARGET:    r_cfg.byte_target    <= i_cfg_data;
                CFG_EXPECTED_RATE:  r_cfg.expected_rate  <= i_cfg_data[31:0];
                CFG_TRANSFER_BYTES: r_cfg.transfer_bytes <= i_cfg_data[31:0];
                CFG_SLOW_LIMIT:     r_cfg.slow_run_limit <= i_cfg_data[7:0];
                CFG_IDLE_LIMIT_US:  r_cfg.idle_limit_us  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Each stage loads when it is empty or its contents move on.
    always_comb begin
        en_out  = !r_out_vld || o_res.ready;
        en.en3  = !r_v3 || en_out;
        en.en2  = !r_v2 || en.en3;
        en1     = !r_v1 || en.en2;
    end

    assign i_evt.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1)    r_v1      <= i_evt.valid;
            if (en.en2) r_v2      <= r_v1;
            if (en.en3) r_v3      <= r_v2;
            if (en_out) r_out_vld <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_got   <= i_evt.rx_bytes;
            r1_now   <= i_evt.now_us;
            r1_since <= i_evt.gap_us;
        end
        if (en.en2) begin
            r2_got  <= r1_got;
            r2_now  <= r1_now;
            r2_hist <= !r1_since[31] && (r1_since != '0);
        end
        if (en.en3) begin
            r3_got  <= r2_got;
            r3_now  <= r2_now;
            r3_hist <= r2_hist;
        end
        if (en_out) begin
            r_out_verdict <= trk_verdict;
            r_out_total   <= trk_total;
        end
    end

    csw_slow_judge u_judge (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_since    (r1_since[30:0]),
        .i_got      (r1_got),
        .i_rate     (r_cfg.expected_rate),
        .i_transfer (r_cfg.transfer_bytes),
        .o_slow     (slow)
    );

    always_comb begin
        judged.got  = r3_got;
        judged.now  = r3_now;
        judged.hist = r3_hist;
        judged.slow = slow;
    end

    csw_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_v3 && en_out),
        .i_cfg     (r_cfg),
        .i_evt     (judged),
        .o_verdict (trk_verdict),
        .o_total   (trk_total)
    );

    assign o_res.valid          = r_out_vld;
    assign o_res.verdict        = r_out_verdict;
    assign o_res.received_total = r_out_total;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en1 |-> (r_v1 && r_v2 && r_v3 && r_out_vld))
        else $error("input stalled with an empty stage");

    a_result_from_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !$past(r_out_vld)) |-> $past(r_v3))
        else $error("result appeared without a judged event");

    a_stall_holds_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en_out) |=> r_v3 && $stable(r3_now))
        else $error("judged event lost while output stalled");

endmodule
